>>> rtl/q8a_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Q24.8 fixed-point ALU.
// No dependencies.
package q8a_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int NUM_W     = DATA_W + FRAC_BITS;  // divider numerator / quotient width
    localparam int PROD_W    = 2 * DATA_W;

    localparam logic [3:0] MODE_ADD = 4'd0;
    localparam logic [3:0] MODE_SUB = 4'd1;
    localparam logic [3:0] MODE_MUL = 4'd2;
    localparam logic [3:0] MODE_DIV = 4'd3;
    localparam logic [3:0] MODE_MIN = 4'd4;
    localparam logic [3:0] MODE_MAX = 4'd5;
    localparam logic [3:0] MODE_INC = 4'd6;
    localparam logic [3:0] MODE_DEC = 4'd7;
    localparam logic [3:0] MODE_I2F = 4'd8;
    localparam logic [3:0] MODE_F2I = 4'd9;

    localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [3:0]               mode;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     a_greater;
        logic                     a_less;
        logic                     a_equal;
        logic                     overflow;
        logic                     div_by_zero;
    } t_out;

    typedef struct packed {
        logic [3:0]               mode;
        logic                     neg;
        logic                     gt;
        logic                     lt;
        logic                     eq;
        logic                     dz;
        logic                     ovf;
        logic signed [DATA_W-1:0] res;
        logic [PROD_W-1:0]        prod;
        logic [DATA_W-1:0]        den;
        logic [DATA_W:0]          rem;
        logic [NUM_W-1:0]         numq;
    } t_pipe;

endpackage

>>> rtl/q8a_pre.sv
`timescale 1ns / 1ps
// Entry stage: compare, simple ops, magnitude multiply, divider setup.
// Depends on q8a_pkg.
module q8a_pre import q8a_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_in   i_data,
    output logic  o_valid,
    output t_pipe o_pipe
);

    logic                     r_valid;
    t_pipe                    r_pipe;
    t_pipe                    n_pipe;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] opnd;
    logic signed [DATA_W:0]   ext;
    logic signed [DATA_W:0]   sum;
    logic                     do_sub;
    logic [DATA_W-1:0]        mag_a;
    logic [DATA_W-1:0]        mag_b;
    logic [FRAC_BITS:0]       top_a;

    always_comb begin
        a      = i_data.operand_a;
        b      = i_data.operand_b;
        mag_a  = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
        mag_b  = b[DATA_W-1] ? DATA_W'(-b) : DATA_W'(b);
        do_sub = (i_data.mode == MODE_SUB) || (i_data.mode == MODE_DEC);
        opnd   = ((i_data.mode == MODE_INC) || (i_data.mode == MODE_DEC))
                 ? DATA_W'(1) : b;
        ext    = {opnd[DATA_W-1], opnd};
        sum    = {a[DATA_W-1], a} + (do_sub ? -ext : ext);
        top_a  = a[DATA_W-1 -: FRAC_BITS+1];

        n_pipe      = '0;
        n_pipe.mode = i_data.mode;
        n_pipe.neg  = a[DATA_W-1] ^ b[DATA_W-1];
        n_pipe.gt   = a > b;
        n_pipe.lt   = a < b;
        n_pipe.eq   = a == b;
        n_pipe.dz   = (i_data.mode == MODE_DIV) && (b == '0);
        n_pipe.prod = PROD_W'(mag_a) * PROD_W'(mag_b);
        n_pipe.den  = mag_b;
        n_pipe.numq = {mag_a, {FRAC_BITS{1'b0}}};
        case (i_data.mode)
            MODE_ADD, MODE_SUB, MODE_INC, MODE_DEC: begin
                if (sum[DATA_W] != sum[DATA_W-1]) begin
                    n_pipe.ovf = 1'b1;
                    n_pipe.res = sum[DATA_W] ? S32_MIN : S32_MAX;
                end else begin
                    n_pipe.res = sum[DATA_W-1:0];
                end
            end
            MODE_MIN: n_pipe.res = (a < b) ? a : b;
            MODE_MAX: n_pipe.res = (a > b) ? a : b;
            MODE_I2F: begin
                if (!((&top_a) || (~|top_a))) begin
                    n_pipe.ovf = 1'b1;
                    n_pipe.res = a[DATA_W-1] ? S32_MIN : S32_MAX;
                end else begin
                    n_pipe.res = a <<< FRAC_BITS;
                end
            end
            MODE_F2I: n_pipe.res = a >>> FRAC_BITS;
            MODE_DIV: n_pipe.res = a[DATA_W-1] ? S32_MIN : S32_MAX;
            default:  n_pipe.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_valid = r_valid;
    assign o_pipe  = r_pipe;

endmodule

>>> rtl/q8a_div_step.sv
`timescale 1ns / 1ps
// One restoring-division step: one quotient bit per stage.
// Depends on q8a_pkg.
module q8a_div_step import q8a_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_pipe i_pipe,
    output logic  o_valid,
    output t_pipe o_pipe
);

    logic            r_valid;
    t_pipe           r_pipe;
    t_pipe           n_pipe;
    logic [DATA_W:0] shifted;
    logic            take;

    always_comb begin
        shifted = {i_pipe.rem[DATA_W-1:0], i_pipe.numq[NUM_W-1]};
        take    = shifted >= {1'b0, i_pipe.den};
        n_pipe      = i_pipe;
        n_pipe.rem  = take ? shifted - {1'b0, i_pipe.den} : shifted;
        n_pipe.numq = {i_pipe.numq[NUM_W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe <= n_pipe;
        end
    end

    assign o_valid = r_valid;
    assign o_pipe  = r_pipe;

endmodule

>>> rtl/q8a_post.sv
`timescale 1ns / 1ps
// Output stage: rounding and saturation of multiply and divide, result register.
// Depends on q8a_pkg.
module q8a_post import q8a_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_pipe i_pipe,
    output logic  o_valid,
    output t_out  o_data
);

    logic              r_valid;
    t_out              r_data;
    t_out              n_data;
    logic [PROD_W:0]   mul_sum;
    logic [PROD_W:0]   mag;
    logic [NUM_W:0]    quo;
    logic [DATA_W+1:0] rem2;

    always_comb begin
        mul_sum = {1'b0, i_pipe.prod} + (PROD_W+1)'(1 << (FRAC_BITS - 1));
        rem2    = {i_pipe.rem, 1'b0};
        quo     = {1'b0, i_pipe.numq}
                  + (NUM_W+1)'(rem2 >= {2'b0, i_pipe.den});
        mag     = (i_pipe.mode == MODE_MUL) ? (mul_sum >> FRAC_BITS)
                                            : (PROD_W+1)'(quo);

        n_data.a_greater   = i_pipe.gt;
        n_data.a_less      = i_pipe.lt;
        n_data.a_equal     = i_pipe.eq;
        n_data.div_by_zero = i_pipe.dz;
        n_data.overflow    = i_pipe.ovf;
        n_data.result      = i_pipe.res;
        if (((i_pipe.mode == MODE_MUL) || (i_pipe.mode == MODE_DIV)) && !i_pipe.dz) begin
            if (i_pipe.neg) begin
                if (mag > ((PROD_W+1)'(1) << (DATA_W-1))) begin
                    n_data.overflow = 1'b1;
                    n_data.result   = S32_MIN;
                end else begin
                    n_data.result   = DATA_W'(-mag);
                end
            end else begin
                if (mag > (PROD_W+1)'(S32_MAX)) begin
                    n_data.overflow = 1'b1;
                    n_data.result   = S32_MAX;
                end else begin
                    n_data.result   = DATA_W'(mag);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> rtl/fixed_point_q24_8_alu.sv
`timescale 1ns / 1ps
// Signed Q24.8 ALU, top level: entry stage, divider pipeline, output stage.
// Depends on q8a_pkg, q8a_pre, q8a_div_step, q8a_post.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one item: mode
//   and two raw 32-bit operands. Output channel (o_out_valid / i_out_ready /
//   o_out_data) returns one result item per input item, in order.
//   The pipeline has 42 register stages: 1 entry stage, 40 divider steps and
//   1 output stage, since the restoring divider resolves one quotient bit
//   per stage. Every mode takes the same path, so throughput is one item
//   per cycle while the receiver does not stall the output.
//   The whole pipeline advances when the output register is empty or taken;
//   while the receiver stalls with a result held, o_in_ready is low and
//   every stage holds its item, so nothing is lost or repeated.
//   Reset (synchronous, active low) clears all valid bits; the pipeline is
//   empty and ready once reset is released.
//   Overflow saturates to the 32-bit limits; divide by zero returns the
//   limit matching the dividend sign and raises div_by_zero.
module fixed_point_q24_8_alu import q8a_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic  en;
    logic  stg_valid [NUM_W+1];
    t_pipe stg_pipe  [NUM_W+1];

    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    q8a_pre u_pre (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (stg_valid[0]),
        .o_pipe  (stg_pipe[0])
    );

    for (genvar g = 0; g < NUM_W; g++) begin : g_div
        q8a_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (stg_valid[g]),
            .i_pipe  (stg_pipe[g]),
            .o_valid (stg_valid[g+1]),
            .o_pipe  (stg_pipe[g+1])
        );
    end

    q8a_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (stg_valid[NUM_W]),
        .i_pipe  (stg_pipe[NUM_W]),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot({o_out_data.a_greater, o_out_data.a_less,
                                 o_out_data.a_equal}))
        else $error("comparison flags not one-hot");

    a_dz_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.div_by_zero) |-> !o_out_data.overflow)
        else $error("div_by_zero with overflow");

    a_dz_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.div_by_zero) |->
        (o_out_data.result == S32_MAX || o_out_data.result == S32_MIN))
        else $error("div_by_zero result not saturated");

    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.overflow) |->
        (o_out_data.result == S32_MAX || o_out_data.result == S32_MIN))
        else $error("overflow result not saturated");
`endif

endmodule
